FILE: rtl/core/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, codes and calendar helpers for the Gregorian date decrement
// unit.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam logic [2:0] OP_DAY        = 3'd0;
    localparam logic [2:0] OP_WEEK       = 3'd1;
    localparam logic [2:0] OP_MONTH      = 3'd2;
    localparam logic [2:0] OP_YEAR       = 3'd3;
    localparam logic [2:0] OP_DECADE     = 3'd4;
    localparam logic [2:0] OP_CENTURY    = 3'd5;
    localparam logic [2:0] OP_MILLENNIUM = 3'd6;
    localparam logic [2:0] OP_NONE       = 3'd7;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_MONTH = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam int         UNIT_BITS     = 10;
    localparam logic [9:0] UNIT_YEAR     = 10'd1;
    localparam logic [9:0] UNIT_DECADE   = 10'd10;
    localparam logic [9:0] UNIT_CENTURY  = 10'd100;
    localparam logic [9:0] UNIT_MILLENNIUM = 10'd1000;

    localparam logic [2:0] DAYS_PER_WEEK = 3'd7;
    localparam logic [4:0] MOD25         = 5'd25;
    localparam logic [4:0] MOD25_NEG_ONE = 5'd24;

    // multiple of 25 that keeps the folded year positive
    localparam logic [11:0] FOLD_BIAS = 12'd2050;
    // ceil(2^16 / 25), exact quotient for values below 4096
    localparam logic [11:0] RECIP25   = 12'd2622;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MOD,
        ST_WALK,
        ST_MUL,
        ST_YSUB,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic walk_step;
        logic mul;
        logic ysub;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       bad_month;
        logic       mod_last;
        logic       walk_done;
    } dp_status_t;

    // y divisible by 4/100/400 from low bits of y and y mod 25
    function automatic logic is_leap(input logic [3:0] y_low, input logic [4:0] res25);
        logic by4;
        logic by16;
        by4  = (y_low[1:0] == 2'd0);
        by16 = (y_low == 4'd0);
        return (by4 && (res25 != 5'd0)) || (by16 && (res25 == 5'd0));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/gregorian_date_decrement_unit.sv
// Sequence: day, week and month items first take the year residue mod 25 by a fold and a
//   reduction, then walk back step by step, a step being one month crossed or the last move inside a month.
// Year, decade, century and millennium items multiply, then subtract; bad months and op 7 go straight to done.
// Throughput: one item at a time; the next item is accepted in the cycle after the result is
//   registered, and a result held by m_tready low holds the unit.
// Reset: asynchronous active-low rst_n returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
// gregorian_date_decrement_unit
// Moves a Gregorian date back by a count of days, weeks, months, years,
// decades, centuries or millennia.
// ----------------------------------------------------------------------------
module gregorian_date_decrement_unit #(
    parameter int COUNT_BITS = 16,
    parameter int YEAR_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // op[2:0], count, start_year, start_month[3:0], start_day[4:0], zero pad
    input  logic [((COUNT_BITS+YEAR_BITS+12+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // year, month[3:0], day[4:0], status[1:0], zero pad
    output logic [((YEAR_BITS+11+7)/8)*8-1:0] m_tdata
);
    import gdd_pkg::*;

    localparam int OUT_W = ((YEAR_BITS + 11 + 7) / 8) * 8;
    localparam int CB0   = 3;
    localparam int YB0   = CB0 + COUNT_BITS;
    localparam int MB0   = YB0 + YEAR_BITS;
    localparam int DB0   = MB0 + 4;

    dp_cmd_t                     cmd;
    dp_status_t                  status;
    logic signed [YEAR_BITS-1:0] year;
    logic [3:0]                  month;
    logic [4:0]                  day;
    logic [1:0]                  result_status;

    gdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gdd_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .YEAR_BITS  (YEAR_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .op            (s_tdata[2:0]),
        .count         (s_tdata[YB0-1:CB0]),
        .start_year    (s_tdata[MB0-1:YB0]),
        .start_month   (s_tdata[DB0-1:MB0]),
        .start_day     (s_tdata[DB0+4:DB0]),
        .year          (year),
        .month         (month),
        .day           (day),
        .result_status (result_status)
    );

    assign m_tdata = OUT_W'({result_status, day, month, year});

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in work");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_status != STAT_BAD_MONTH |-> month >= MONTH_JAN && month <= MONTH_DEC)
        else $error("result month out of range");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> result_status == STAT_OK || result_status == STAT_BAD_MONTH
                     || result_status == STAT_UNDERFLOW)
        else $error("undefined status code");
`endif

endmodule

FILE: rtl/core/gdd_ctrl.sv
// ----------------------------------------------------------------------------
// gdd_ctrl
// Sequencer for the date decrement unit: accepts an item, steps the datapath
// through its phases and holds the result handshake.
// ----------------------------------------------------------------------------
module gdd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  gdd_pkg::dp_status_t status,
    output gdd_pkg::dp_cmd_t    cmd
);
    import gdd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (status.bad_month || status.op == OP_NONE)
                    state_next = ST_DONE;
                else if (status.op == OP_DAY || status.op == OP_WEEK
                         || status.op == OP_MONTH)
                    state_next = ST_MOD;
                else
                    state_next = ST_MUL;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.walk_done)
                    state_next = ST_DONE;
                else
                    cmd.walk_step = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_YSUB;
            end
            ST_YSUB:
            begin
                cmd.ysub   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/core/gdd_datapath.sv
// ----------------------------------------------------------------------------
// gdd_datapath
// Date registers, year residue mod 25, month walker and year-step
// multiply/subtract for the date decrement unit.
// ----------------------------------------------------------------------------
module gdd_datapath #(
    parameter int COUNT_BITS = 16,
    parameter int YEAR_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gdd_pkg::dp_cmd_t            cmd,
    output gdd_pkg::dp_status_t         status,
    input  logic [2:0]                  op,
    input  logic [COUNT_BITS-1:0]       count,
    input  logic signed [YEAR_BITS-1:0] start_year,
    input  logic [3:0]                  start_month,
    input  logic [4:0]                  start_day,
    output logic signed [YEAR_BITS-1:0] year,
    output logic [3:0]                  month,
    output logic [4:0]                  day,
    output logic [1:0]                  result_status
);
    import gdd_pkg::*;

    localparam int RW = COUNT_BITS + 3;
    localparam int PW = COUNT_BITS + UNIT_BITS;
    localparam int DW = ((YEAR_BITS > PW) ? YEAR_BITS : PW) + 2;
    localparam logic signed [YEAR_BITS-1:0] YEAR_MIN = {1'b1, {(YEAR_BITS-1){1'b0}}};
    // weight of the sign bit, mod 25
    localparam logic [4:0] SIGN_RES = 5'((64'd1 << (YEAR_BITS - 1)) % 64'd25);

    logic [2:0]                  op_reg;
    logic [RW-1:0]               r_reg, r_next;
    logic signed [YEAR_BITS-1:0] y_reg, y_next;
    logic [3:0]                  m_reg, m_next;
    logic [4:0]                  d_reg, d_next;
    logic [1:0]                  st_reg, st_next;
    logic [4:0]                  res_reg, res_next;
    logic [11:0]                 fold_reg, fold_next;
    logic                        mod_phase_reg, mod_phase_next;
    logic [PW-1:0]               prod_reg;
    logic signed [YEAR_BITS-1:0] out_year_reg;
    logic [3:0]                  out_month_reg;
    logic [4:0]                  out_day_reg;
    logic [1:0]                  out_status_reg;

    logic                        wrap;
    logic signed [YEAR_BITS-1:0] y_dec;
    logic [3:0]                  m_dec;
    logic [4:0]                  res_dec;
    logic [4:0]                  len_dec;
    logic [31:0]                 u_ext;
    logic [20:0]                 fold_sum;
    logic [11:0]                 fold_val;
    logic [23:0]                 recip_prod;
    logic [7:0]                  quot;
    logic [11:0]                 quot_25;
    logic [4:0]                  res_fold;
    logic [9:0]                  unit;
    logic [DW-1:0]               diff;
    logic [DW-1:0]               min_ext;

    always_comb
    begin
        wrap    = (m_reg == MONTH_JAN);
        m_dec   = wrap ? MONTH_DEC : m_reg - 4'd1;
        y_dec   = wrap ? y_reg - YEAR_BITS'(1) : y_reg;
        res_dec = wrap ? ((res_reg == 5'd0) ? MOD25_NEG_ONE : res_reg - 5'd1) : res_reg;
        len_dec = month_days(m_dec, is_leap(y_dec[3:0], res_dec));
        // offset year folded with 2^20 = 1 and 2^10 = -1 mod 25
        u_ext    = 32'({~y_reg[YEAR_BITS-1], y_reg[YEAR_BITS-2:0]});
        fold_sum = 21'(u_ext[19:0]) + 21'(u_ext[31:20]);
        fold_val = 12'(fold_sum[9:0]) + FOLD_BIAS - 12'(fold_sum[20:10])
                   + 12'(MOD25 - SIGN_RES);
        recip_prod = 24'(fold_reg) * 24'(RECIP25);
        quot       = recip_prod[23:16];
        quot_25    = 12'(quot) * 12'(MOD25);
        res_fold   = 5'(fold_reg - quot_25);
        unique case (op_reg)
            OP_DECADE:     unit = UNIT_DECADE;
            OP_CENTURY:    unit = UNIT_CENTURY;
            OP_MILLENNIUM: unit = UNIT_MILLENNIUM;
            default:       unit = UNIT_YEAR;
        endcase
        diff    = {{(DW-YEAR_BITS){y_reg[YEAR_BITS-1]}}, y_reg} - {{(DW-PW){1'b0}}, prod_reg};
        min_ext = {{(DW-YEAR_BITS){1'b1}}, YEAR_MIN};
    end

    always_comb
    begin
        r_next         = r_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        fold_next      = fold_reg;
        mod_phase_next = mod_phase_reg;
        if (cmd.load)
        begin
            r_next         = (op == OP_WEEK) ? RW'(count) * RW'(DAYS_PER_WEEK) : RW'(count);
            y_next         = start_year;
            m_next         = start_month;
            d_next         = start_day;
            st_next        = (start_month < MONTH_JAN || start_month > MONTH_DEC)
                             ? STAT_BAD_MONTH : STAT_OK;
            mod_phase_next = 1'b0;
        end
        else if (cmd.mod_step)
        begin
            if (!mod_phase_reg)
            begin
                fold_next      = fold_val;
                mod_phase_next = 1'b1;
            end
            else
                res_next = res_fold;
        end
        else if (cmd.walk_step)
        begin
            if (op_reg != OP_MONTH && RW'(d_reg) > r_reg)
            begin
                d_next = d_reg - r_reg[4:0];
                r_next = '0;
            end
            else if (wrap && y_reg == YEAR_MIN)
            begin
                y_next  = YEAR_MIN;
                m_next  = MONTH_JAN;
                d_next  = 5'd1;
                st_next = STAT_UNDERFLOW;
                r_next  = '0;
            end
            else
            begin
                if (op_reg == OP_MONTH)
                begin
                    r_next = r_reg - RW'(1);
                    d_next = (d_reg > len_dec) ? len_dec : d_reg;
                end
                else
                begin
                    r_next = r_reg - ((d_reg == 5'd0) ? RW'(1) : RW'(d_reg));
                    d_next = len_dec;
                end
                m_next   = m_dec;
                y_next   = y_dec;
                res_next = res_dec;
            end
        end
        else if (cmd.ysub)
        begin
            if ($signed(diff) < $signed(min_ext))
            begin
                y_next  = YEAR_MIN;
                st_next = STAT_UNDERFLOW;
            end
            else
                y_next = diff[YEAR_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= OP_NONE;
        else if (cmd.load)
            op_reg <= op;
    end

    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        y_reg         <= y_next;
        m_reg         <= m_next;
        d_reg         <= d_next;
        st_reg        <= st_next;
        res_reg       <= res_next;
        fold_reg      <= fold_next;
        mod_phase_reg <= mod_phase_next;
        if (cmd.mul)
            prod_reg <= PW'(r_reg[COUNT_BITS-1:0]) * PW'(unit);
        if (cmd.publish)
        begin
            out_year_reg   <= y_reg;
            out_month_reg  <= m_reg;
            out_day_reg    <= d_reg;
            out_status_reg <= st_reg;
        end
    end

    assign status.op        = op_reg;
    assign status.bad_month = (st_reg == STAT_BAD_MONTH);
    assign status.mod_last  = mod_phase_reg;
    assign status.walk_done = (r_reg == '0);

    assign year          = out_year_reg;
    assign month         = out_month_reg;
    assign day           = out_day_reg;
    assign result_status = out_status_reg;

endmodule

FILE: verif/gregorian_date_decrement_unit_tb.sv
// ----------------------------------------------------------------------------
// gregorian_date_decrement_unit_tb
// Streams date items into the decrement unit under random bursts and
// back-pressure. Each accepted item is scored against a calendar predictor:
// day and week walks with leap years, month steps with day clamping, year
// multiples with saturation, bad months and underflow.
// ----------------------------------------------------------------------------
module gregorian_date_decrement_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gdd_pkg::*;

    localparam int     COUNT_BITS = 16;
    localparam int     YEAR_BITS  = 16;
    localparam int     S_BITS     = ((COUNT_BITS + YEAR_BITS + 12 + 7) / 8) * 8;
    localparam int     M_BITS     = ((YEAR_BITS + 11 + 7) / 8) * 8;
    localparam longint YEAR_LOW   = -(longint'(1) << (YEAR_BITS - 1));
    localparam int     N_RANDOM   = 1320;

    typedef struct {
        logic [2:0]                  op;
        logic [COUNT_BITS-1:0]       count;
        logic signed [YEAR_BITS-1:0] year;
        logic [3:0]                  month;
        logic [4:0]                  day;
        bit                          drain;
    } date_req_t;

    typedef struct {
        logic signed [YEAR_BITS-1:0] year;
        logic [3:0]                  month;
        logic [4:0]                  day;
        logic [1:0]                  status;
    } date_res_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;

    date_req_t pending_dates[$];
    date_res_t expected_dates[$];
    date_req_t next_req;
    date_req_t taken_req;
    date_res_t seen_date;
    date_res_t want_date;
    logic      due_empty = 1'b1;
    int        burst_left;
    int        gap_left;
    rx_mode_t  stall_mode;
    int        mode_left;
    logic [7:0] stall_phase;
    int        mismatches;
    int        n_walk;
    int        n_yearstep;
    int        n_bad;
    int        n_under;
    int        n_results;

    gregorian_date_decrement_unit #(
        .COUNT_BITS(COUNT_BITS),
        .YEAR_BITS (YEAR_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic int month_length(input longint y, input int m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        if (m == MONTH_FEB)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic date_res_t shift_date_back(input date_req_t r);
        date_res_t res;
        date_res_t sat;
        longint    y;
        longint    rem;
        longint    ny;
        longint    unit_yrs;
        longint    step;
        int        m;
        int        d;
        y   = r.year;
        m   = r.month;
        d   = r.day;
        res = '{year: r.year, month: r.month, day: r.day, status: STAT_OK};
        sat = '{year: YEAR_LOW[YEAR_BITS-1:0], month: MONTH_JAN, day: 5'd1,
                status: STAT_UNDERFLOW};
        if (m < MONTH_JAN || m > MONTH_DEC)
        begin
            res.status = STAT_BAD_MONTH;
            return res;
        end
        if (r.op == OP_DAY || r.op == OP_WEEK)
        begin
            rem = (r.op == OP_WEEK) ? longint'(r.count) * DAYS_PER_WEEK : longint'(r.count);
            while (rem > 0)
            begin
                if (d > rem)
                begin
                    d   = d - int'(rem);
                    rem = 0;
                end
                else
                begin
                    rem = rem - ((d == 0) ? 1 : d);
                    m   = m - 1;
                    if (m < MONTH_JAN)
                    begin
                        if (y == YEAR_LOW)
                            return sat;
                        m = MONTH_DEC;
                        y = y - 1;
                    end
                    d = month_length(y, m);
                end
            end
        end
        else if (r.op == OP_MONTH)
        begin
            for (step = 0; step < r.count; step++)
            begin
                m = m - 1;
                if (m < MONTH_JAN)
                begin
                    if (y == YEAR_LOW)
                        return sat;
                    m = MONTH_DEC;
                    y = y - 1;
                end
                if (d > month_length(y, m))
                    d = month_length(y, m);
            end
        end
        else if (r.op != OP_NONE)
        begin
            case (r.op)
                OP_YEAR:    unit_yrs = UNIT_YEAR;
                OP_DECADE:  unit_yrs = UNIT_DECADE;
                OP_CENTURY: unit_yrs = UNIT_CENTURY;
                default:    unit_yrs = UNIT_MILLENNIUM;
            endcase
            ny = y - longint'(r.count) * unit_yrs;
            if (ny < YEAR_LOW)
            begin
                res.year   = YEAR_LOW[YEAR_BITS-1:0];
                res.status = STAT_UNDERFLOW;
                return res;
            end
            y = ny;
        end
        res.year  = y[YEAR_BITS-1:0];
        res.month = m[3:0];
        res.day   = d[4:0];
        return res;
    endfunction

    function automatic date_req_t date_item(input logic [2:0] op, input int count, input int year,
                                            input int month, input int day);
        date_req_t r;
        r.op    = op;
        r.count = count[COUNT_BITS-1:0];
        r.year  = year[YEAR_BITS-1:0];
        r.month = month[3:0];
        r.day   = day[4:0];
        r.drain = 1'b0;
        return r;
    endfunction

    function automatic date_req_t random_date_request();
        date_req_t r;
        int        pick;
        bit        huge;
        pick    = $urandom_range(0, 99);
        huge    = ($urandom_range(0, 149) == 0);
        r.drain = 1'b0;
        if (pick < 22)
            r.op = OP_DAY;
        else if (pick < 38)
            r.op = OP_WEEK;
        else if (pick < 60)
            r.op = OP_MONTH;
        else if (pick < 96)
            r.op = 3'($urandom_range(OP_YEAR, OP_MILLENNIUM));
        else
            r.op = OP_NONE;
        if ($urandom_range(0, 7) == 0)
            r.year = {1'b1, 15'($urandom_range(0, 40))};
        else
            r.year = YEAR_BITS'($urandom);
        if ($urandom_range(0, 24) == 0)
            r.month = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
        else
            r.month = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
        if ($urandom_range(0, 9) == 0)
            r.day = 5'($urandom_range(0, 31));
        else
            r.day = 5'($urandom_range(1, month_length(r.year, r.month)));
        case (r.op)
            OP_DAY:
                r.count = huge ? COUNT_BITS'($urandom) : ($urandom_range(0, 9) == 0)
                          ? COUNT_BITS'($urandom_range(0, 4000))
                          : COUNT_BITS'($urandom_range(0, 400));
            OP_WEEK:
                r.count = huge ? COUNT_BITS'($urandom) : ($urandom_range(0, 9) == 0)
                          ? COUNT_BITS'($urandom_range(0, 600))
                          : COUNT_BITS'($urandom_range(0, 60));
            OP_MONTH:
                r.count = huge ? COUNT_BITS'($urandom) : ($urandom_range(0, 9) == 0)
                          ? COUNT_BITS'($urandom_range(0, 1000))
                          : COUNT_BITS'($urandom_range(0, 40));
            default:
                r.count = ($urandom_range(0, 3) == 0) ? COUNT_BITS'($urandom_range(0, 40))
                          : COUNT_BITS'($urandom);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // sender: bursts of items with random gaps, optional drain before an item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_dates.size() == 0 ||
                     (pending_dates[0].drain && (s_tvalid || !due_empty)))
            begin
                s_tvalid <= 1'b0;
            end
            else
            begin
                next_req = pending_dates.pop_front();
                s_tdata  <= S_BITS'({next_req.day, next_req.month, next_req.year,
                                     next_req.count, next_req.op});
                s_tvalid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: stall pattern picked at random among open, coin flip, periodic and sparse
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_mode  <= RX_OPEN;
            mode_left   <= 0;
            stall_phase <= '0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= rx_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(32, 256);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            stall_phase <= stall_phase + 1'b1;
            case (stall_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_tready <= (stall_phase[1:0] != 2'd0);
                default:     m_tready <= (stall_phase[2:0] == 3'd0);
            endcase
        end
    end

    // monitor: predict on accepted items, score accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_empty <= 1'b1;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                taken_req.op    = s_tdata[2:0];
                taken_req.count = s_tdata[3 +: COUNT_BITS];
                taken_req.year  = s_tdata[3 + COUNT_BITS +: YEAR_BITS];
                taken_req.month = s_tdata[3 + COUNT_BITS + YEAR_BITS +: 4];
                taken_req.day   = s_tdata[7 + COUNT_BITS + YEAR_BITS +: 5];
                taken_req.drain = 1'b0;
                want_date       = shift_date_back(taken_req);
                expected_dates.push_back(want_date);
                if (want_date.status == STAT_BAD_MONTH)
                    n_bad++;
                else if (taken_req.op <= OP_MONTH)
                    n_walk++;
                else if (taken_req.op != OP_NONE)
                    n_yearstep++;
                if (want_date.status == STAT_UNDERFLOW)
                    n_under++;
            end
            if (m_tvalid && m_tready)
            begin
                seen_date.year   = m_tdata[YEAR_BITS-1:0];
                seen_date.month  = m_tdata[YEAR_BITS +: 4];
                seen_date.day    = m_tdata[YEAR_BITS + 4 +: 5];
                seen_date.status = m_tdata[YEAR_BITS + 9 +: 2];
                n_results++;
                if (expected_dates.size() == 0)
                begin
                    report_mismatch("result with none expected", m_tdata, 0);
                end
                else
                begin
                    want_date = expected_dates.pop_front();
                    if (seen_date.year != want_date.year)
                        report_mismatch("year", seen_date.year, want_date.year);
                    if (seen_date.month != want_date.month)
                        report_mismatch("month", seen_date.month, want_date.month);
                    if (seen_date.day != want_date.day)
                        report_mismatch("day", seen_date.day, want_date.day);
                    if (seen_date.status != want_date.status)
                        report_mismatch("status", seen_date.status, want_date.status);
                end
            end
            due_empty <= (expected_dates.size() == 0);
        end
    end

    initial
    begin
        date_req_t r;
        // bad months echo the start fields
        pending_dates.push_back(date_item(OP_DAY, 5, 2024, 0, 10));
        pending_dates.push_back(date_item(OP_MONTH, 3, -5, 13, 0));
        pending_dates.push_back(date_item(OP_YEAR, 1, 100, 15, 31));
        // unused op and zero counts
        pending_dates.push_back(date_item(OP_NONE, 100, 1999, 6, 15));
        pending_dates.push_back(date_item(OP_DAY, 0, 2023, 7, 4));
        pending_dates.push_back(date_item(OP_MONTH, 0, 2023, 7, 31));
        // leap rule at month and year borders
        pending_dates.push_back(date_item(OP_DAY, 1, 2000, 3, 1));
        pending_dates.push_back(date_item(OP_DAY, 1, 1900, 3, 1));
        pending_dates.push_back(date_item(OP_DAY, 1, 2024, 1, 1));
        // zero start day
        pending_dates.push_back(date_item(OP_DAY, 1, 2023, 5, 0));
        pending_dates.push_back(date_item(OP_MONTH, 2, 2023, 5, 0));
        pending_dates.push_back(date_item(OP_YEAR, 1, 2023, 5, 0));
        // start day beyond month length, clamping
        pending_dates.push_back(date_item(OP_DAY, 3, 2023, 2, 31));
        pending_dates.push_back(date_item(OP_MONTH, 1, 2024, 3, 31));
        pending_dates.push_back(date_item(OP_MONTH, 13, 2024, 3, 31));
        pending_dates.push_back(date_item(OP_WEEK, 1, 2024, 3, 3));
        // year multiples
        pending_dates.push_back(date_item(OP_DECADE, 3, 2024, 12, 31));
        pending_dates.push_back(date_item(OP_CENTURY, 7, 1600, 2, 29));
        pending_dates.push_back(date_item(OP_MILLENNIUM, 2, 2000, 1, 1));
        // underflow and the exact lowest year
        pending_dates.push_back(date_item(OP_DAY, 10, -32768, 1, 5));
        pending_dates.push_back(date_item(OP_MONTH, 5, -32768, 2, 10));
        pending_dates.push_back(date_item(OP_MILLENNIUM, 5, -32000, 4, 4));
        pending_dates.push_back(date_item(OP_YEAR, 65535, 32767, 6, 6));
        pending_dates.push_back(date_item(OP_YEAR, 1, -32768, 1, 1));
        // longest walks
        pending_dates.push_back(date_item(OP_DAY, 65535, 32767, 12, 31));
        pending_dates.push_back(date_item(OP_WEEK, 65535, 32767, 12, 31));
        pending_dates.push_back(date_item(OP_MONTH, 65535, 32767, 12, 31));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            r       = random_date_request();
            r.drain = (i % 250 == 0);
            pending_dates.push_back(r);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_dates.size() != 0 || s_tvalid)
            @(posedge clk);
        while (!due_empty)
            @(posedge clk);
        repeat (YEAR_BITS + 32) @(posedge clk);

        $display("run covered %0d results: %0d day/week/month walks, %0d year steps,",
                 n_results, n_walk, n_yearstep);
        $display("%0d bad-month items and %0d underflows, %0d mismatches",
                 n_bad, n_under, mismatches);
        if (mismatches == 0 && expected_dates.size() == 0)
        begin
            $display("gregorian_date_decrement_unit_tb: PASS");
        end
        else
        begin
            $display("gregorian_date_decrement_unit_tb: FAIL");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("run timed out with %0d results outstanding", expected_dates.size());
        $display("gregorian_date_decrement_unit_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/gdd_pkg.sv
rtl/core/gdd_ctrl.sv
rtl/core/gdd_datapath.sv
rtl/core/gregorian_date_decrement_unit.sv
verif/gregorian_date_decrement_unit_tb.sv
